### hw/rtl/pdmc_pkg.sv
// ----------------------------------------------------------------------------
// pdmc_pkg
// Shared types and constants of the press duration mode controller.
// ----------------------------------------------------------------------------
`default_nettype none

package pdmc_pkg;

   // controller modes
   localparam logic [1:0] MODE_OFF       = 2'd0;
   localparam logic [1:0] MODE_SLEEP_OFF = 2'd1;
   localparam logic [1:0] MODE_MEASURE   = 2'd2;
   localparam logic [1:0] MODE_SLEEP_ON  = 2'd3;

   // register indexes on the csr port
   localparam int unsigned CSR_IDX_BITS = 3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PAUSE_THR   = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ONOFF_THR   = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPECIAL_THR = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_RESET_THR   = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_WARN_MIN    = 3'd4;

   localparam int unsigned CSR_DATA_BITS = 32;

   // register reset values
   localparam logic [31:0] PAUSE_THR_RST   = 32'd500;
   localparam logic [31:0] ONOFF_THR_RST   = 32'd1000;
   localparam logic [31:0] SPECIAL_THR_RST = 32'd2000;
   localparam logic [31:0] RESET_THR_RST   = 32'd3000;
   localparam logic [15:0] WARN_MIN_RST    = 16'd25;

   localparam int unsigned REQ_DATA_BITS = 88;
   localparam int unsigned RSP_DATA_BITS = 152;

   typedef struct packed {
      logic [31:0] pause_thr;
      logic [31:0] onoff_thr;
      logic [31:0] special_thr;
      logic [31:0] reset_thr;
      logic [15:0] warn_floor_cm;
   } cfg_type;

   // request beat, last member in the lowest bits
   typedef struct packed {
      logic [5:0]  pad;
      logic [31:0] now_ms;
      logic [15:0] range_cm;
      logic        measure_ready;
      logic        any_activity;
      logic [31:0] press_ms;
   } req_type;

   // response beat, last member in the lowest bits
   typedef struct packed {
      logic [31:0] pause_tally;
      logic [31:0] pause_time_total_ms;
      logic [31:0] on_time_total_ms;
      logic [31:0] measurement_count;
      logic        stats_valid;
      logic        paused;
      logic        sleep_request;
      logic [15:0] shown_distance;
      logic        display_on;
      logic        ranging_on;
      logic        clear_press;
      logic [1:0]  mode;
   } rsp_type;

   // press duration classes
   typedef struct packed {
      logic reset;
      logic onoff;
      logic pause;
      logic special;
   } guard_type;

   function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

endpackage

`default_nettype wire

### hw/rtl/pdmc_decode.sv
// ----------------------------------------------------------------------------
// pdmc_decode
// Sorts a press duration into the reset, on/off, pause and special classes.
// ----------------------------------------------------------------------------
`default_nettype none

module pdmc_decode
   import pdmc_pkg::*;
(
   input  wire logic [31:0] press_ms,
   input  wire cfg_type     cfg,
   output guard_type        guards
);

   // all threshold compares are strict
   always_comb begin
      guards.reset   = press_ms > cfg.reset_thr;
      guards.onoff   = (press_ms > cfg.onoff_thr) && (press_ms < cfg.special_thr);
      guards.pause   = (press_ms > cfg.pause_thr) && (press_ms < cfg.onoff_thr);
      guards.special = (press_ms > cfg.special_thr) && (press_ms < cfg.reset_thr);
   end

endmodule

`default_nettype wire

### hw/rtl/pdmc_fsm.sv
// ----------------------------------------------------------------------------
// pdmc_fsm
// Mode state machine with flags and statistics; one firing per enable.
// ----------------------------------------------------------------------------
`default_nettype none

module pdmc_fsm
   import pdmc_pkg::*;
#(
   parameter int unsigned TIME_BITS = 32
)(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      fire,
   input  wire req_type   item,
   input  wire guard_type guards,
   input  wire logic [15:0] warn_floor_cm,
   output rsp_type        result
);

   // timestamps keep at most 32 bits
   localparam int unsigned TW = (TIME_BITS < 32) ? TIME_BITS : 32;

   logic [1:0]    mode_ff, mode_in;
   logic          paused_ff, paused_in;
   logic          ranging_ff, ranging_in;
   logic          display_ff, display_in;
   logic [15:0]   dist_ff, dist_in;
   logic          special_ff, special_in;
   logic [31:0]   meas_ff, meas_in;
   logic [31:0]   on_total_ff, on_total_in;
   logic [31:0]   pause_total_ff, pause_total_in;
   logic [31:0]   pauses_ff, pauses_in;
   logic [TW-1:0] on_since_ff, on_since_in;
   logic [TW-1:0] pause_since_ff, pause_since_in;

   logic [TW-1:0] now_t;
   logic [TW-1:0] on_elapsed;
   logic [TW-1:0] pause_elapsed;
   logic [15:0]   warn_half;
   logic          clear;
   logic          sleep;

   assign now_t         = item.now_ms[TW-1:0];
   assign on_elapsed    = now_t - on_since_ff;
   assign pause_elapsed = now_t - pause_since_ff;
   assign warn_half     = warn_floor_cm >> 1;

   always_comb begin
      mode_in        = mode_ff;
      paused_in      = paused_ff;
      ranging_in     = ranging_ff;
      display_in     = display_ff;
      dist_in        = dist_ff;
      special_in     = special_ff;
      meas_in        = meas_ff;
      on_total_in    = on_total_ff;
      pause_total_in = pause_total_ff;
      pauses_in      = pauses_ff;
      on_since_in    = on_since_ff;
      pause_since_in = pause_since_ff;
      clear          = 1'b0;
      sleep          = 1'b0;

      if (guards.reset) begin
         // clear everything but the shown distance
         clear          = 1'b1;
         mode_in        = MODE_OFF;
         paused_in      = 1'b0;
         ranging_in     = 1'b0;
         display_in     = 1'b0;
         special_in     = 1'b0;
         meas_in        = '0;
         on_total_in    = '0;
         pause_total_in = '0;
         pauses_in      = '0;
         on_since_in    = '0;
         pause_since_in = '0;
      end else begin
         case (mode_ff)
            MODE_OFF: begin
               if (guards.onoff) begin
                  clear       = 1'b1;
                  on_since_in = now_t;
                  ranging_in  = 1'b1;
                  display_in  = 1'b1;
                  mode_in     = MODE_MEASURE;
               end else if (!item.any_activity) begin
                  sleep   = 1'b1;
                  mode_in = MODE_SLEEP_OFF;
               end
            end
            MODE_SLEEP_OFF: begin
               if (item.any_activity) begin
                  mode_in = MODE_OFF;
               end else begin
                  sleep = 1'b1;
               end
            end
            MODE_MEASURE: begin
               if (guards.special) begin
                  clear      = 1'b1;
                  special_in = 1'b1;
                  if (on_since_ff != '0) begin
                     on_total_in = sat_add(on_total_ff, 32'(on_elapsed));
                     on_since_in = now_t;
                  end
                  if (paused_ff && (pause_since_ff != '0)) begin
                     pause_total_in = sat_add(pause_total_ff, 32'(pause_elapsed));
                     pause_since_in = now_t;
                  end
               end else if (guards.pause) begin
                  clear      = 1'b1;
                  paused_in  = !paused_ff;
                  display_in = paused_ff;
                  if (!paused_ff) begin
                     pauses_in      = sat_add(pauses_ff, 32'd1);
                     pause_since_in = now_t;
                  end else begin
                     pause_total_in = sat_add(pause_total_ff, 32'(pause_elapsed));
                  end
               end else if (item.measure_ready) begin
                  meas_in = sat_add(meas_ff, 32'd1);
                  if (!paused_ff || (item.range_cm < warn_half)) begin
                     dist_in    = item.range_cm;
                     display_in = 1'b1;
                  end else begin
                     display_in = 1'b0;
                  end
               end else if (guards.onoff) begin
                  clear       = 1'b1;
                  ranging_in  = 1'b0;
                  display_in  = 1'b0;
                  paused_in   = 1'b0;
                  on_total_in = sat_add(on_total_ff, 32'(on_elapsed));
                  mode_in     = MODE_OFF;
               end else if (!item.any_activity) begin
                  sleep   = 1'b1;
                  mode_in = MODE_SLEEP_ON;
               end
            end
            default: begin
               // sleep while measuring
               if (item.measure_ready) begin
                  mode_in = MODE_MEASURE;
               end else if (!item.any_activity) begin
                  sleep = 1'b1;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_OFF;
         paused_ff      <= 1'b0;
         ranging_ff     <= 1'b0;
         display_ff     <= 1'b0;
         dist_ff        <= '0;
         special_ff     <= 1'b0;
         meas_ff        <= '0;
         on_total_ff    <= '0;
         pause_total_ff <= '0;
         pauses_ff      <= '0;
         on_since_ff    <= '0;
         pause_since_ff <= '0;
      end else if (fire) begin
         mode_ff        <= mode_in;
         paused_ff      <= paused_in;
         ranging_ff     <= ranging_in;
         display_ff     <= display_in;
         dist_ff        <= dist_in;
         special_ff     <= special_in;
         meas_ff        <= meas_in;
         on_total_ff    <= on_total_in;
         pause_total_ff <= pause_total_in;
         pauses_ff      <= pauses_in;
         on_since_ff    <= on_since_in;
         pause_since_ff <= pause_since_in;
      end
   end

   // response shows the state after the firing
   always_comb begin
      result.mode                = mode_in;
      result.clear_press         = clear;
      result.ranging_on          = ranging_in;
      result.display_on          = display_in;
      result.shown_distance      = dist_in;
      result.sleep_request       = sleep;
      result.paused              = paused_in;
      result.stats_valid         = special_in;
      result.measurement_count   = meas_in;
      result.on_time_total_ms    = on_total_in;
      result.pause_time_total_ms = pause_total_in;
      result.pause_tally         = pauses_in;
   end

endmodule

`default_nettype wire

### hw/rtl/press_duration_mode_controller_core.sv
// ----------------------------------------------------------------------------
// press_duration_mode_controller_core
// Four-mode controller driven by button press duration, one response per beat.
// Flow: request beat into the input register, then the mode/statistics update
//   (combinational) written together with the response register.
// Throughput: 1 beat per cycle while the response channel is not stalled.
// Reset: synchronous, active high; clears mode, flags, statistics and pipeline
//   valids, and loads the threshold registers with their defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module press_duration_mode_controller_core
   import pdmc_pkg::*;
#(
   parameter int unsigned TIME_BITS = 32
)(
   input  wire logic                     clock,
   input  wire logic                     reset,
   // request channel
   input  wire logic                     req_tvalid,
   output      logic                     req_tready,
   // tdata: press_ms[31:0], any_activity[32], measure_ready[33],
   //        range_cm[49:34], now_ms[81:50], zero pad[87:82]
   input  wire logic [REQ_DATA_BITS-1:0] req_tdata,
   // response channel
   output      logic                     rsp_tvalid,
   input  wire logic                     rsp_tready,
   // tdata: mode[1:0], clear_press[2], ranging_on[3], display_on[4],
   //        shown_distance[20:5], sleep_request[21], paused[22],
   //        stats_valid[23], measurement_count[55:24],
   //        on_time_total_ms[87:56], pause_time_total_ms[119:88],
   //        pause_tally[151:120]
   output      logic [RSP_DATA_BITS-1:0] rsp_tdata,
   // register write port
   input  wire logic                     csr_we,
   input  wire logic [CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [CSR_DATA_BITS-1:0] csr_wdata
);

   // threshold registers
   cfg_type   cfg_ff;

   // input register stage
   logic      in_valid_ff;
   req_type   in_item_ff;

   // response register
   logic      out_valid_ff;
   rsp_type   out_data_ff;

   guard_type guards;
   rsp_type   result;
   logic      fire;

   // a beat moves from the input register to the response register when
   // the response slot is empty or being drained this cycle
   assign fire       = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pause_thr     <= PAUSE_THR_RST;
         cfg_ff.onoff_thr     <= ONOFF_THR_RST;
         cfg_ff.special_thr   <= SPECIAL_THR_RST;
         cfg_ff.reset_thr     <= RESET_THR_RST;
         cfg_ff.warn_floor_cm <= WARN_MIN_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PAUSE_THR:   cfg_ff.pause_thr     <= csr_wdata;
            CSR_ONOFF_THR:   cfg_ff.onoff_thr     <= csr_wdata;
            CSR_SPECIAL_THR: cfg_ff.special_thr   <= csr_wdata;
            CSR_RESET_THR:   cfg_ff.reset_thr     <= csr_wdata;
            CSR_WARN_MIN:    cfg_ff.warn_floor_cm <= csr_wdata[15:0];
            default: begin
               // unmapped index: write dropped
            end
         endcase
      end
   end

   // input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_item_ff <= req_type'(req_tdata);
      end
   end

   pdmc_decode u_decode (
      .press_ms (in_item_ff.press_ms),
      .cfg      (cfg_ff),
      .guards   (guards)
   );

   pdmc_fsm #(
      .TIME_BITS (TIME_BITS)
   ) u_fsm (
      .clock         (clock),
      .reset         (reset),
      .fire          (fire),
      .item          (in_item_ff),
      .guards        (guards),
      .warn_floor_cm (cfg_ff.warn_floor_cm),
      .result        (result)
   );

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (fire) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_data_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

`default_nettype wire

### hw/rtl/pdmc_checker.sv
// ----------------------------------------------------------------------------
// pdmc_checker
// Port-level assertions for the press duration mode controller.
// ----------------------------------------------------------------------------
`default_nettype none

module pdmc_checker
   import pdmc_pkg::*;
(
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     rsp_tvalid,
   input wire logic                     rsp_tready,
   input wire logic [RSP_DATA_BITS-1:0] rsp_tdata
);

   rsp_type rsp;
   assign rsp = rsp_type'(rsp_tdata);

   // stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response beat changed while stalled");

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // a sleep request always lands in a sleep mode
   a_sleep_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp.sleep_request |->
         (rsp.mode == MODE_SLEEP_OFF) || (rsp.mode == MODE_SLEEP_ON))
      else $error("sleep request outside a sleep mode");

   // pause only exists while ranging
   a_pause_ranging: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp.paused |-> rsp.ranging_on)
      else $error("paused without ranging");

   // off mode never leaves ranging running
   a_off_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp.mode == MODE_OFF) |-> !rsp.ranging_on)
      else $error("ranging on in off mode");

endmodule

bind press_duration_mode_controller_core pdmc_checker u_pdmc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
